// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/hxb_pkg.sv
// Types, codes and constants of the hex text to byte buffer.
package hxb_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int STORE_AW = $clog2(STORE_DEPTH);
	localparam int LEN_W = 9;
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(STORE_DEPTH);
	localparam logic [LEN_W-1:0] CAP_RESET = 9'd256;

	localparam int QDEPTH = 2;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] REG_CAPACITY = 2'd0;

	localparam logic [1:0] ACT_CHAR = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [2:0] ST_TAKEN = 3'd0;
	localparam logic [2:0] ST_ACCEPT = 3'd1;
	localparam logic [2:0] ST_REJECT = 3'd2;
	localparam logic [2:0] ST_IGNORED = 3'd3;
	localparam logic [2:0] ST_READ_OK = 3'd4;
	localparam logic [2:0] ST_READ_OOR = 3'd5;
	localparam logic [2:0] ST_CLEARED = 3'd6;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;

	typedef enum logic [1:0] {
		CK_DIGIT,
		CK_SEP,
		CK_TERM,
		CK_BAD
	} char_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PAIR,
		PH_LOW,
		PH_DROP
	} phase_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
		logic [7:0] read_index;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] byte_value;
		logic [LEN_W-1:0] stored_length;
	} rsp_t;

	typedef struct packed {
		logic [1:0] action;
		char_kind_t kind;
		logic [3:0] nibble;
		logic [7:0] read_index;
	} cls_item_t;

endpackage

// File: rtl/hxb_front.sv
// Front end: accepts request beats and classifies text characters.
module hxb_front (
	input  logic             req_valid,
	output logic             req_ready,
	input  hxb_pkg::req_t    req,
	output logic             push,
	output hxb_pkg::cls_item_t push_item,
	input  logic             q_ready
);
	import hxb_pkg::*;

	logic [7:0] c;

	assign c = req.char_code;
	assign req_ready = q_ready;
	assign push = req_valid && q_ready;

	always_comb begin
		push_item.action = req.action;
		push_item.read_index = req.read_index;
		push_item.nibble = 4'd0;
		push_item.kind = CK_BAD;
		if (c == CH_NUL) begin
			push_item.kind = CK_TERM;
		end else if (c == CH_SPACE || c == CH_COLON || c == CH_DASH) begin
			push_item.kind = CK_SEP;
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			push_item.kind = CK_DIGIT;
			push_item.nibble = 4'(c - CH_ZERO);
		end else if (c >= CH_LA && c <= CH_LF) begin
			push_item.kind = CK_DIGIT;
			push_item.nibble = 4'(c - CH_LA + 8'd10);
		end else if (c >= CH_UA && c <= CH_UF) begin
			push_item.kind = CK_DIGIT;
			push_item.nibble = 4'(c - CH_UA + 8'd10);
		end
	end

endmodule

// File: rtl/hxb_queue.sv
// Short queue of classified beats between front and back end.
`include "assert_macros.svh"
module hxb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hxb_pkg::cls_item_t push_item,
	output logic               q_ready,
	output logic               q_valid,
	output hxb_pkg::cls_item_t q_item,
	input  logic               pop
);
	import hxb_pkg::*;

	cls_item_t        ent_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QCW-1:0]   cnt_q;

	assign q_ready = cnt_q < QCW'(QDEPTH);
	assign q_valid = cnt_q != '0;
	assign q_item = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_item;
	end

	`ASSERT_ALWAYS(a_cnt_bound, cnt_q <= QCW'(QDEPTH))
	`ASSERT_NEXT(a_cnt_push, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`ASSERT_ALWAYS(a_no_pop_empty, !pop || q_valid)

endmodule

// File: rtl/hxb_back.sv
// Back end: string state machine, byte store and result register.
`include "assert_macros.svh"
module hxb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  hxb_pkg::cls_item_t          q_item,
	output logic                        pop,
	input  logic [hxb_pkg::LEN_W-1:0]   capacity,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output hxb_pkg::rsp_t               rsp
);
	import hxb_pkg::*;

	logic [7:0]       store_q [STORE_DEPTH];
	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] fill_q, fill_d;
	logic [LEN_W-1:0] start_q, start_d;
	logic [LEN_W-1:0] start_eff;
	logic [LEN_W-1:0] limit;
	logic [3:0]       hi_q, hi_d;
	logic [2:0]       st_d;
	logic             we;
	logic             rd_ok;
	logic             fire;

	logic             valid_s2;
	logic [2:0]       st_s2;
	logic [LEN_W-1:0] len_s2;
	logic             rdok_s2;
	logic [7:0]       rd_q;

	assign fire = q_valid && (!valid_s2 || rsp_ready);
	assign pop = fire;
	assign start_eff = (phase_q == PH_IDLE) ? fill_q : start_q;
	assign limit = (capacity < DEPTH_LEN) ? capacity : DEPTH_LEN;
	assign rd_ok = ({1'b0, q_item.read_index} < fill_q)
		&& ({1'b0, q_item.read_index} < DEPTH_LEN);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (q_item.action == ACT_CHAR) begin
			unique case (phase_q) inside
				PH_DROP: begin
					if (q_item.kind == CK_TERM) phase_d = PH_IDLE;
				end
				PH_IDLE, PH_PAIR: begin
					unique case (q_item.kind)
						CK_TERM: phase_d = PH_IDLE;
						CK_SEP: phase_d = PH_PAIR;
						CK_DIGIT: phase_d = PH_LOW;
						CK_BAD: phase_d = PH_DROP;
					endcase
				end
				PH_LOW: begin
					if (q_item.kind == CK_TERM) phase_d = PH_IDLE;
					else if (q_item.kind == CK_DIGIT && fill_q < limit) phase_d = PH_PAIR;
					else phase_d = PH_DROP;
				end
			endcase
		end
	end

	// step effects
	always_comb begin
		st_d = ST_IGNORED;
		fill_d = fill_q;
		start_d = start_q;
		hi_d = hi_q;
		we = 1'b0;
		unique case (q_item.action)
			ACT_CHAR: begin
				if (phase_q != PH_DROP) start_d = start_eff;
				unique case (phase_q) inside
					PH_DROP: st_d = ST_IGNORED;
					PH_IDLE, PH_PAIR: begin
						unique case (q_item.kind)
							CK_TERM: st_d = ST_ACCEPT;
							CK_SEP: st_d = ST_TAKEN;
							CK_DIGIT: begin
								st_d = ST_TAKEN;
								hi_d = q_item.nibble;
							end
							CK_BAD: begin
								st_d = ST_REJECT;
								fill_d = start_eff;
							end
						endcase
					end
					PH_LOW: begin
						if (q_item.kind == CK_DIGIT && fill_q < limit) begin
							st_d = ST_TAKEN;
							we = 1'b1;
							fill_d = fill_q + 1'b1;
						end else begin
							st_d = ST_REJECT;
							fill_d = start_eff;
						end
					end
				endcase
			end
			ACT_READ: st_d = rd_ok ? ST_READ_OK : ST_READ_OOR;
			ACT_CLEAR: begin
				st_d = ST_CLEARED;
				fill_d = '0;
				start_d = '0;
			end
			default: st_d = ST_IGNORED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fill_q <= '0;
			start_q <= '0;
			hi_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				fill_q <= fill_d;
				start_q <= start_d;
				hi_q <= hi_d;
			end
			if (fire) valid_s2 <= 1'b1;
			else if (rsp_ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			st_s2 <= st_d;
			len_s2 <= fill_d;
			rdok_s2 <= (q_item.action == ACT_READ) && rd_ok;
		end
		if (fire && q_item.action == ACT_READ) rd_q <= store_q[q_item.read_index[STORE_AW-1:0]];
		if (fire && we) store_q[fill_q[STORE_AW-1:0]] <= {hi_q, q_item.nibble};
	end

	assign rsp_valid = valid_s2;
	assign rsp.status = st_s2;
	assign rsp.byte_value = rdok_s2 ? rd_q : 8'd0;
	assign rsp.stored_length = len_s2;

	`ASSERT_ALWAYS(a_fill_bound, fill_q <= DEPTH_LEN)
	`ASSERT_NEXT(a_reject_rollback, fire && st_d == ST_REJECT, fill_q == $past(start_eff))
	`ASSERT_NEXT(a_drop_holds,
		fire && phase_q == PH_DROP && !(q_item.action == ACT_CHAR && q_item.kind == CK_TERM),
		phase_q == PH_DROP)

endmodule

// File: rtl/hex_text_to_byte_buffer.sv
// Hex text to byte buffer: top level with capacity register.
// Path: an accepted request beat is registered in the queue and then in the back-end result
// register before it shows on rsp; a stall on rsp_ready delays it further.
// Throughput: one beat per cycle while rsp_ready keeps the result register free, set by
// the back-end step with one store write and one registered store read per cycle.
// Reset: phase idle, lengths zero, capacity 256; store contents stay undefined.
module hex_text_to_byte_buffer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  hxb_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output hxb_pkg::rsp_t                 rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hxb_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import hxb_pkg::*;

	logic             push;
	logic             pop;
	logic             q_ready;
	logic             q_valid;
	cls_item_t        push_item;
	cls_item_t        q_item;
	logic [LEN_W-1:0] cap_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_CAPACITY) ? {{(32 - LEN_W){1'b0}}, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr == REG_CAPACITY) begin
			cap_q <= pwdata[LEN_W-1:0];
		end
	end

	hxb_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready)
	);

	hxb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop)
	);

	hxb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.capacity  (cap_q),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
